FILE: hdl/tsos_pkg.sv
// Shared types and constants for the TCP SYN option scanner.
// Holds the walk phase encoding, the result record and the frame layout constants.
// Used by tsos_parser and tcp_syn_option_scanner_top; depends on nothing else.
`timescale 1ns / 1ps

package tsos_pkg;

    // Bytes past this position are ignored (range 64 .. 65535)
    localparam logic [16:0] MAX_FRAME_BYTES = 17'd16384;

    // Ethernet header layout
    localparam logic [15:0] POS_ETH_HI     = 16'd12;
    localparam logic [15:0] POS_ETH_LO     = 16'd13;
    localparam logic [15:0] ETH_TYPE_IPV4  = 16'h0800;
    localparam logic [15:0] ETH_TYPE_VLAN  = 16'h8100;
    localparam logic [4:0]  OFF_IPV4       = 5'd14;
    localparam logic [4:0]  OFF_VLAN       = 5'd18;
    localparam logic [4:0]  OFF_NONE       = 5'd0;

    // Fixed IP header length, and TCP header fields relative to its start
    localparam logic [15:0] IP_HDR_BYTES   = 16'd20;
    localparam logic [15:0] REL_SRC_HI     = 16'd0;
    localparam logic [15:0] REL_SRC_LO     = 16'd1;
    localparam logic [15:0] REL_DST_HI     = 16'd2;
    localparam logic [15:0] REL_DST_LO     = 16'd3;
    localparam logic [15:0] REL_FLAGS      = 16'd13;
    localparam logic [16:0] FLAGS_TO_OPTS  = 17'd7;
    localparam int          TCP_FLAG_SYN   = 1;

    // Option kinds
    localparam logic [7:0]  OPT_EOL        = 8'd0;
    localparam logic [7:0]  OPT_NOP        = 8'd1;
    localparam logic [7:0]  OPT_MPTCP      = 8'd30;
    localparam logic [7:0]  OPT_MIN_LEN    = 8'd2;

    // Frame class codes
    localparam logic [1:0]  CLASS_UNKNOWN  = 2'd0;
    localparam logic [1:0]  CLASS_TCP      = 2'd1;
    localparam logic [1:0]  CLASS_SYN      = 2'd2;

    localparam logic [31:0] SYN_COUNT_MAX  = 32'hFFFF_FFFF;
    localparam logic [15:0] POS_MAX        = 16'hFFFF;

    // Option walk phase
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_KIND = 4'b0010,
        PH_BODY = 4'b0100,
        PH_STOP = 4'b1000
    } walk_phase_t;

    // One per-frame result
    typedef struct packed {
        logic [31:0] syn_total;
        logic        option_error;
        logic [3:0]  mptcp_subtype;
        logic        mptcp_found;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [1:0]  frame_class;
    } tsos_result_t;

endpackage

FILE: hdl/tsos_parser.sv
// Per-byte frame parser: ethertype, TCP ports, SYN flag and the TCP option walk.
// Emits one result record with the final byte of each frame.
// Depends on tsos_pkg.
`timescale 1ns / 1ps

module tsos_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    input  logic [7:0]            frame_byte,
    input  logic                  last_byte,
    output logic                  res_valid,
    output tsos_pkg::tsos_result_t res
);

    import tsos_pkg::*;

    logic [15:0] pos_reg, pos_next;
    logic [4:0]  hdr_off_reg, hdr_off_next;
    logic [7:0]  eth_hi_reg, eth_hi_next;
    logic [1:0]  class_reg, class_next;
    logic [15:0] src_port_reg, src_port_next;
    logic [15:0] dst_port_reg, dst_port_next;
    walk_phase_t phase_reg, phase_next;
    logic [15:0] nos_reg, nos_next;
    logic [15:0] opt_begin_reg, opt_begin_next;
    logic        seen_reg, seen_next;
    logic [3:0]  subtype_reg, subtype_next;
    logic        err_reg, err_next;
    logic        pending_reg, pending_next;
    logic [31:0] syn_cnt_reg, syn_cnt_next;

    logic [15:0] tcp_base;
    logic [15:0] rel;
    logic [16:0] opt_start_sum;
    logic [16:0] opt_end_sum;
    logic [16:0] pos_plus1;

    // Offsets and sums used by the field capture and the walk
    assign tcp_base      = {11'b0, hdr_off_reg} + IP_HDR_BYTES;
    assign rel           = pos_reg - tcp_base;
    assign opt_start_sum = {1'b0, pos_reg} + FLAGS_TO_OPTS;
    assign opt_end_sum   = {1'b0, opt_begin_reg} + {9'b0, frame_byte};
    assign pos_plus1     = {1'b0, pos_reg} + 17'd1;

    // Next-state logic for one accepted word
    always_comb
    begin
        pos_next       = pos_reg;
        hdr_off_next   = hdr_off_reg;
        eth_hi_next    = eth_hi_reg;
        class_next     = class_reg;
        src_port_next  = src_port_reg;
        dst_port_next  = dst_port_reg;
        phase_next     = phase_reg;
        nos_next       = nos_reg;
        opt_begin_next = opt_begin_reg;
        seen_next      = seen_reg;
        subtype_next   = subtype_reg;
        err_next       = err_reg;
        pending_next   = pending_reg;
        syn_cnt_next   = syn_cnt_reg;
        res_valid      = 1'b0;
        res            = '0;

        if (byte_valid)
        begin
            if ({1'b0, pos_reg} < MAX_FRAME_BYTES)
            begin
                // Decode the ethertype
                if (pos_reg == POS_ETH_HI)
                begin
                    eth_hi_next = frame_byte;
                end
                else if (pos_reg == POS_ETH_LO)
                begin
                    priority if ({eth_hi_reg, frame_byte} == ETH_TYPE_IPV4)
                    begin
                        hdr_off_next = OFF_IPV4;
                        class_next   = CLASS_TCP;
                    end
                    else if ({eth_hi_reg, frame_byte} == ETH_TYPE_VLAN)
                    begin
                        hdr_off_next = OFF_VLAN;
                        class_next   = CLASS_TCP;
                    end
                    else
                    begin
                        hdr_off_next = OFF_NONE;
                        class_next   = CLASS_UNKNOWN;
                    end
                end

                // Capture ports and detect SYN in the fixed TCP header
                if (hdr_off_reg != OFF_NONE && pos_reg >= tcp_base)
                begin
                    priority if (rel == REL_SRC_HI)
                    begin
                        src_port_next = {frame_byte, 8'b0};
                    end
                    else if (rel == REL_SRC_LO)
                    begin
                        src_port_next = {src_port_reg[15:8], frame_byte};
                    end
                    else if (rel == REL_DST_HI)
                    begin
                        dst_port_next = {frame_byte, 8'b0};
                    end
                    else if (rel == REL_DST_LO)
                    begin
                        dst_port_next = {dst_port_reg[15:8], frame_byte};
                    end
                    else if (rel == REL_FLAGS && frame_byte[TCP_FLAG_SYN])
                    begin
                        class_next = CLASS_SYN;
                        if (syn_cnt_reg != SYN_COUNT_MAX)
                        begin
                            syn_cnt_next = syn_cnt_reg + 32'd1;
                        end
                        phase_next = PH_KIND;
                        nos_next   = opt_start_sum[16] ? POS_MAX : opt_start_sum[15:0];
                    end
                end

                // Walk the option list
                unique case (phase_reg)
                    PH_KIND:
                    begin
                        if (pos_reg == nos_reg)
                        begin
                            priority if (frame_byte == OPT_EOL)
                            begin
                                phase_next = PH_STOP;
                            end
                            else if (frame_byte == OPT_NOP)
                            begin
                                nos_next = pos_plus1[15:0];
                            end
                            else
                            begin
                                opt_begin_next = pos_reg;
                                phase_next     = PH_BODY;
                                if (frame_byte == OPT_MPTCP && !seen_reg)
                                begin
                                    seen_next    = 1'b1;
                                    subtype_next = 4'd0;
                                    pending_next = 1'b1;
                                end
                            end
                        end
                    end
                    PH_BODY:
                    begin
                        if (pos_reg > opt_begin_reg)
                        begin
                            if (pos_reg == opt_begin_reg + 16'd1 && frame_byte < OPT_MIN_LEN)
                            begin
                                // Zero or one length: flag and stop
                                err_next     = 1'b1;
                                phase_next   = PH_STOP;
                                pending_next = 1'b0;
                            end
                            else
                            begin
                                if (pos_reg == opt_begin_reg + 16'd1)
                                begin
                                    nos_next = opt_end_sum[16] ? POS_MAX : opt_end_sum[15:0];
                                end
                                else if (pending_reg && pos_reg == opt_begin_reg + 16'd2)
                                begin
                                    subtype_next = frame_byte[7:4];
                                    pending_next = 1'b0;
                                end
                                if (pos_plus1 == {1'b0, nos_next})
                                begin
                                    phase_next   = PH_KIND;
                                    pending_next = 1'b0;
                                end
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Advance the position, saturating
            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 16'd1;
            end

            // Report on the final word and clear the frame state
            if (last_byte)
            begin
                res_valid           = 1'b1;
                res.frame_class     = class_next;
                res.source_port     = src_port_next;
                res.dest_port       = dst_port_next;
                res.mptcp_found     = seen_next;
                res.mptcp_subtype   = subtype_next;
                res.option_error    = err_next || (phase_next == PH_BODY);
                res.syn_total       = syn_cnt_next;

                pos_next       = '0;
                hdr_off_next   = OFF_NONE;
                eth_hi_next    = '0;
                class_next     = CLASS_UNKNOWN;
                src_port_next  = '0;
                dst_port_next  = '0;
                phase_next     = PH_IDLE;
                nos_next       = '0;
                opt_begin_next = '0;
                seen_next      = 1'b0;
                subtype_next   = '0;
                err_next       = 1'b0;
                pending_next   = 1'b0;
            end
        end
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            hdr_off_reg   <= OFF_NONE;
            eth_hi_reg    <= '0;
            class_reg     <= CLASS_UNKNOWN;
            src_port_reg  <= '0;
            dst_port_reg  <= '0;
            phase_reg     <= PH_IDLE;
            nos_reg       <= '0;
            opt_begin_reg <= '0;
            seen_reg      <= 1'b0;
            subtype_reg   <= '0;
            err_reg       <= 1'b0;
            pending_reg   <= 1'b0;
            syn_cnt_reg   <= '0;
        end
        else
        begin
            pos_reg       <= pos_next;
            hdr_off_reg   <= hdr_off_next;
            eth_hi_reg    <= eth_hi_next;
            class_reg     <= class_next;
            src_port_reg  <= src_port_next;
            dst_port_reg  <= dst_port_next;
            phase_reg     <= phase_next;
            nos_reg       <= nos_next;
            opt_begin_reg <= opt_begin_next;
            seen_reg      <= seen_next;
            subtype_reg   <= subtype_next;
            err_reg       <= err_next;
            pending_reg   <= pending_next;
            syn_cnt_reg   <= syn_cnt_next;
        end
    end

endmodule

FILE: hdl/tcp_syn_option_scanner_top.sv
// TCP SYN option scanner, top level: byte stream in, one summary word per frame out.
// The summary is registered in the output word, or in the skid word if that is held.
// Throughput: one byte per cycle; s_tready drops only while the output word and its
// skid word are both full.
// Reset (rst_n low, asynchronous): frame state, SYN count and output buffer are cleared.
// Depends on tsos_pkg and tsos_parser.
`timescale 1ns / 1ps

module tcp_syn_option_scanner_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] frame_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [15:0] source_port, [31:16] dest_port, [32] mptcp_found,
                                   // [36:33] mptcp_subtype, [37] option_error,
                                   // [69:38] syn_total, [71:70] zero
    output logic [1:0]  m_tuser    // [1:0] frame_class
);

    import tsos_pkg::*;

    logic         byte_take;
    logic         res_valid;
    tsos_result_t res;

    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    tsos_result_t out_data_reg, out_data_next;
    tsos_result_t skid_data_reg, skid_data_next;
    logic         out_fire;

    assign s_tready  = !skid_valid_reg;
    assign byte_take = s_tvalid && s_tready;
    assign out_fire  = out_valid_reg && m_tready;

    tsos_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_take),
        .frame_byte (s_tdata),
        .last_byte  (s_tlast),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Output word with a skid word behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_data_next  = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold the buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold the buffer payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // Pack the master side word
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.frame_class;
    assign m_tdata  = {2'b00,
                       out_data_reg.syn_total,
                       out_data_reg.option_error,
                       out_data_reg.mptcp_subtype,
                       out_data_reg.mptcp_found,
                       out_data_reg.dest_port,
                       out_data_reg.source_port};

endmodule

FILE: tb/sv/tcp_syn_option_scanner_top_test.sv
// Self-checking testbench for tcp_syn_option_scanner_top: frames go in byte by byte,
// per-frame summaries are predicted in the bench and compared field by field.
// Depends on tsos_pkg and the scanner RTL only.
`timescale 1ns / 1ps

module tcp_syn_option_scanner_top_test;

    import tsos_pkg::*;

    localparam int          HALF_PERIOD   = 6;
    localparam int          RESET_CYCLES  = 11;
    localparam int          QUIET_LIMIT   = 2000;
    localparam int          HOLD_CYCLES   = 600;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int          PHASE_BYTES   = 30;
    localparam int          PHASE_FRAMES  = 1;
    localparam int          BURST_FRAMES  = 24;

    localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86DD;
    localparam logic [15:0] ETH_TYPE_NEAR = 16'h0801;
    localparam logic [7:0]  OPT_MSS       = 8'd2;
    localparam logic [7:0]  OPT_WSCALE    = 8'd3;
    localparam logic [7:0]  OPT_TSTAMP    = 8'd8;
    localparam logic [7:0]  FLAGS_SYN     = 8'h02;
    localparam logic [7:0]  FLAGS_NO_SYN  = 8'hFD;
    localparam logic [7:0]  FLAGS_ALL     = 8'hFF;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;

    // Side information that travels with each driven word
    logic         drv_typed;
    tsos_result_t drv_want;

    // One directed frame: header fields, option bytes (first byte highest), payload, cut
    typedef struct {
        logic [15:0]  etype;
        logic [7:0]   flags;
        logic [15:0]  sport;
        logic [15:0]  dport;
        logic [127:0] opts;
        int           n_opts;
        int           n_pay;
        logic [7:0]   pay_val;
        int           cut;
        bit           typed;
        tsos_result_t want;
    } frame_row_t;

    frame_row_t   frame_rows[$];
    logic [7:0]   frame_bytes[$];
    logic [7:0]   opt_bytes[$];
    tsos_result_t pending_summaries[$];

    int sender_idle_pct;
    int receiver_stall_pct;
    bit hold_request;
    int mismatch_count;
    int summary_count;
    int quiet_cycles;

    // Scanner state mirrored in the bench
    logic [15:0]  scan_pos;
    logic [4:0]   scan_hdr_off;
    logic [7:0]   scan_etype_hi;
    logic [1:0]   scan_class;
    logic [15:0]  scan_sport;
    logic [15:0]  scan_dport;
    walk_phase_t  scan_phase;
    int           scan_next_opt;
    int           scan_opt_begin;
    bit           scan_mp_seen;
    logic [3:0]   scan_mp_sub;
    bit           scan_opt_err;
    bit           scan_cap_pend;
    logic [31:0]  scan_syn_count;

    tcp_syn_option_scanner_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // Per-frame state goes back to its reset value after every last byte
    task automatic clear_frame_state();
        scan_pos       = '0;
        scan_hdr_off   = OFF_NONE;
        scan_etype_hi  = '0;
        scan_class     = CLASS_UNKNOWN;
        scan_sport     = '0;
        scan_dport     = '0;
        scan_phase     = PH_IDLE;
        scan_next_opt  = 0;
        scan_opt_begin = 0;
        scan_mp_seen   = 1'b0;
        scan_mp_sub    = '0;
        scan_opt_err   = 1'b0;
        scan_cap_pend  = 1'b0;
    endtask

    // Advance the scanner by one byte; a last byte yields the frame summary
    task automatic scan_byte(input logic [7:0] b, input logic last,
                             output bit has_res, output tsos_result_t res);
        int p;
        int tcp_base;
        int rel;
        bit stopped;
        p       = int'(scan_pos);
        has_res = 1'b0;
        res     = '0;
        stopped = 1'b0;
        if (p < int'(MAX_FRAME_BYTES))
        begin
            // Ethertype decides where the IP header starts
            if (p == int'(POS_ETH_HI))
                scan_etype_hi = b;
            else if (p == int'(POS_ETH_LO))
            begin
                if ({scan_etype_hi, b} == ETH_TYPE_IPV4)
                begin
                    scan_hdr_off = OFF_IPV4;
                    scan_class   = CLASS_TCP;
                end
                else if ({scan_etype_hi, b} == ETH_TYPE_VLAN)
                begin
                    scan_hdr_off = OFF_VLAN;
                    scan_class   = CLASS_TCP;
                end
                else
                begin
                    scan_hdr_off = OFF_NONE;
                    scan_class   = CLASS_UNKNOWN;
                end
            end

            // Capture ports and the SYN flag from the fixed TCP header
            tcp_base = int'(scan_hdr_off) + int'(IP_HDR_BYTES);
            if (scan_hdr_off != OFF_NONE && p >= tcp_base)
            begin
                rel = p - tcp_base;
                if (rel == int'(REL_SRC_HI))
                    scan_sport = {b, 8'h00};
                else if (rel == int'(REL_SRC_LO))
                    scan_sport = scan_sport | {8'h00, b};
                else if (rel == int'(REL_DST_HI))
                    scan_dport = {b, 8'h00};
                else if (rel == int'(REL_DST_LO))
                    scan_dport = scan_dport | {8'h00, b};
                else if (rel == int'(REL_FLAGS) && b[TCP_FLAG_SYN])
                begin
                    scan_class = CLASS_SYN;
                    if (scan_syn_count != SYN_COUNT_MAX)
                        scan_syn_count = scan_syn_count + 32'd1;
                    scan_phase    = PH_KIND;
                    scan_next_opt = p + int'(FLAGS_TO_OPTS);
                end
            end

            // Option walk
            if (scan_phase == PH_KIND && p == scan_next_opt)
            begin
                if (b == OPT_EOL)
                    scan_phase = PH_STOP;
                else if (b == OPT_NOP)
                    scan_next_opt = p + 1;
                else
                begin
                    scan_opt_begin = p;
                    scan_phase     = PH_BODY;
                    if (b == OPT_MPTCP && !scan_mp_seen)
                    begin
                        scan_mp_seen  = 1'b1;
                        scan_mp_sub   = '0;
                        scan_cap_pend = 1'b1;
                    end
                end
            end
            else if (scan_phase == PH_BODY && p > scan_opt_begin)
            begin
                if (p == scan_opt_begin + 1)
                begin
                    if (b < OPT_MIN_LEN)
                    begin
                        scan_opt_err  = 1'b1;
                        scan_phase    = PH_STOP;
                        scan_cap_pend = 1'b0;
                        stopped       = 1'b1;
                    end
                    else
                    begin
                        scan_next_opt = scan_opt_begin + int'(b);
                        if (scan_next_opt > int'(POS_MAX))
                            scan_next_opt = int'(POS_MAX);
                    end
                end
                else if (scan_cap_pend && p == scan_opt_begin + 2)
                begin
                    scan_mp_sub   = b[7:4];
                    scan_cap_pend = 1'b0;
                end
                if (!stopped && p + 1 == scan_next_opt)
                begin
                    scan_phase    = PH_KIND;
                    scan_cap_pend = 1'b0;
                end
            end
        end
        if (scan_pos < POS_MAX)
            scan_pos = scan_pos + 16'd1;

        if (last)
        begin
            // An option still open at the frame end is truncated
            if (scan_phase == PH_BODY)
                scan_opt_err = 1'b1;
            res.frame_class   = scan_class;
            res.source_port   = scan_sport;
            res.dest_port     = scan_dport;
            res.mptcp_found   = scan_mp_seen;
            res.mptcp_subtype = scan_mp_sub;
            res.option_error  = scan_opt_err;
            res.syn_total     = scan_syn_count;
            has_res           = 1'b1;
            clear_frame_state();
        end
    endtask

    function automatic tsos_result_t plain_summary(logic [1:0] cls, logic [15:0] sp,
                                                   logic [15:0] dp, logic [31:0] syns);
        tsos_result_t res;
        res             = '0;
        res.frame_class = cls;
        res.source_port = sp;
        res.dest_port   = dp;
        res.syn_total   = syns;
        return res;
    endfunction

    task automatic add_row(logic [15:0] etype, logic [7:0] flags, logic [15:0] sport,
                           logic [15:0] dport, logic [127:0] opts, int n_opts, int n_pay,
                           logic [7:0] pay_val, int cut, bit typed, tsos_result_t want);
        frame_row_t row;
        row.etype   = etype;
        row.flags   = flags;
        row.sport   = sport;
        row.dport   = dport;
        row.opts    = opts;
        row.n_opts  = n_opts;
        row.n_pay   = n_pay;
        row.pay_val = pay_val;
        row.cut     = cut;
        row.typed   = typed;
        row.want    = want;
        frame_rows.push_back(row);
    endtask

    // Lay out Ethernet, optional VLAN tag, IP and TCP headers, then opt_bytes; cut if asked
    task automatic build_frame(logic [15:0] etype, logic [7:0] flags, logic [15:0] sport,
                               logic [15:0] dport, int cut);
        int i;
        frame_bytes.delete();
        repeat (12) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(etype[15:8]);
        frame_bytes.push_back(etype[7:0]);
        if (etype == ETH_TYPE_VLAN)
            repeat (4) frame_bytes.push_back(8'($urandom));
        repeat (20) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(sport[15:8]);
        frame_bytes.push_back(sport[7:0]);
        frame_bytes.push_back(dport[15:8]);
        frame_bytes.push_back(dport[7:0]);
        repeat (9) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(flags);
        repeat (6) frame_bytes.push_back(8'($urandom));
        for (i = 0; i < opt_bytes.size(); i++)
            frame_bytes.push_back(opt_bytes[i]);
        if (cut > 0)
            while (frame_bytes.size() > cut)
                void'(frame_bytes.pop_back());
    endtask

    // Mostly well-formed frames with random options, plus noise and cut frames
    task automatic random_frame();
        int          r;
        int          k;
        int          len;
        logic [15:0] et;
        logic [7:0]  flags;
        r = $urandom_range(99);
        opt_bytes.delete();
        if (r < 12)
        begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 70)) frame_bytes.push_back(8'($urandom));
            return;
        end
        k  = $urandom_range(99);
        et = (k < 45) ? ETH_TYPE_IPV4 : (k < 85) ? ETH_TYPE_VLAN : 16'($urandom);
        repeat ($urandom_range(0, 5))
        begin
            k = $urandom_range(9);
            case (k)
                0, 1:
                    opt_bytes.push_back(OPT_NOP);
                2:
                    opt_bytes.push_back(OPT_EOL);
                3:
                begin
                    opt_bytes.push_back(OPT_MSS);
                    opt_bytes.push_back(8'd4);
                    repeat (2) opt_bytes.push_back(8'($urandom));
                end
                4, 5, 6:
                begin
                    len = $urandom_range(2, 8);
                    opt_bytes.push_back(OPT_MPTCP);
                    opt_bytes.push_back(8'(len));
                    repeat (len - 2) opt_bytes.push_back(8'($urandom));
                end
                default:
                begin
                    len = $urandom_range(0, 6);
                    opt_bytes.push_back(8'($urandom_range(2, 255)));
                    opt_bytes.push_back(8'(len));
                    if (len >= 2)
                        repeat (len - 2) opt_bytes.push_back(8'($urandom));
                end
            endcase
        end
        repeat ($urandom_range(0, 6)) opt_bytes.push_back(8'($urandom));
        flags = 8'($urandom);
        if ($urandom_range(3) != 0)
            flags[TCP_FLAG_SYN] = 1'b1;
        build_frame(et, flags, 16'($urandom), 16'($urandom), 0);
        // Broken frames end at a random point
        if (r < 25)
        begin
            k = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > k)
                void'(frame_bytes.pop_back());
        end
    endtask

    // Offer frame_bytes one word at a time, with random sender gaps
    task automatic send_frame(bit typed, tsos_result_t want);
        int i;
        for (i = 0; i < frame_bytes.size(); i++)
        begin
            while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid  <= 1'b1;
            s_tdata   <= frame_bytes[i];
            s_tlast   <= (i == frame_bytes.size() - 1);
            drv_typed <= typed;
            drv_want  <= want;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
        end
    endtask

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH summary %0d: %0s", $realtime, summary_count, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%0s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // Receiver: random stalls, plus one long hold-off when asked
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_tready <= !(receiver_stall_pct != 0 &&
                              $urandom_range(99) < receiver_stall_pct);
        end
    end

    // Check summaries leaving the block, predict on words entering it
    always @(posedge clk)
    begin
        bit           has_res;
        tsos_result_t res;
        tsos_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_summaries.size() == 0)
                    report_mismatch("summary with none expected");
                else
                begin
                    want = pending_summaries.pop_front();
                    check_field("frame_class",   32'(m_tuser),         32'(want.frame_class));
                    check_field("source_port",   32'(m_tdata[15:0]),   32'(want.source_port));
                    check_field("dest_port",     32'(m_tdata[31:16]),  32'(want.dest_port));
                    check_field("mptcp_found",   32'(m_tdata[32]),     32'(want.mptcp_found));
                    check_field("mptcp_subtype", 32'(m_tdata[36:33]),  32'(want.mptcp_subtype));
                    check_field("option_error",  32'(m_tdata[37]),     32'(want.option_error));
                    check_field("syn_total",     m_tdata[69:38],       want.syn_total);
                    check_field("pad",           32'(m_tdata[71:70]),  32'd0);
                end
                summary_count++;
            end
            if (s_tvalid && s_tready)
            begin
                scan_byte(s_tdata, s_tlast, has_res, res);
                if (has_res)
                    pending_summaries.push_back(drv_typed ? drv_want : res);
            end
        end
    end

    // Watchdog on cycles where neither side moves a word
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int k;
        int ph;
        int phase_bytes;
        int phase_frames;
        int sender_pcts[4];
        int receiver_pcts[4];

        sender_pcts        = '{0, 88, 0, 25};
        receiver_pcts      = '{0, 0, 88, 25};
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_request       = 1'b0;
        mismatch_count     = 0;
        summary_count      = 0;
        scan_syn_count     = '0;
        clear_frame_state();

        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        drv_typed <= 1'b0;
        drv_want  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames; rows marked typed carry their summary written out
        // one-byte frame, frame ending on the ethertype high byte, then right after it
        add_row(ETH_TYPE_IPV4, 8'h00, 16'h0000, 16'h0000, '0, 0, 0, 8'h00, 1, 1'b1,
                plain_summary(CLASS_UNKNOWN, 16'h0000, 16'h0000, 32'd0));
        add_row(ETH_TYPE_IPV4, 8'h00, 16'h0000, 16'h0000, '0, 0, 0, 8'h00, 13, 1'b1,
                plain_summary(CLASS_UNKNOWN, 16'h0000, 16'h0000, 32'd0));
        add_row(ETH_TYPE_IPV4, 8'h00, 16'h0000, 16'h0000, '0, 0, 0, 8'h00, 14, 1'b1,
                plain_summary(CLASS_TCP, 16'h0000, 16'h0000, 32'd0));
        // unknown ethertype hides ports, SYN and options
        add_row(ETH_TYPE_IPV6, FLAGS_SYN, 16'h1234, 16'h0050,
                128'({OPT_MPTCP, 8'd4, 8'hF0, OPT_EOL}), 4, 0, 8'h00, 0, 1'b1,
                plain_summary(CLASS_UNKNOWN, 16'h0000, 16'h0000, 32'd0));
        // port extremes, every flag but SYN
        add_row(ETH_TYPE_IPV4, FLAGS_NO_SYN, 16'hFFFF, 16'h0000, '0, 0, 0, 8'h00, 0, 1'b1,
                plain_summary(CLASS_TCP, 16'hFFFF, 16'h0000, 32'd0));
        // VLAN SYN ending where the options would start
        add_row(ETH_TYPE_VLAN, FLAGS_SYN, 16'h0000, 16'hFFFF, '0, 0, 0, 8'h00, 0, 1'b1,
                plain_summary(CLASS_SYN, 16'h0000, 16'hFFFF, 32'd1));
        // NOPs, MSS, MPTCP, end of list
        add_row(ETH_TYPE_IPV4, FLAGS_ALL, 16'hC001, 16'h01BB,
                128'({OPT_NOP, OPT_NOP, OPT_MSS, 8'd4, 8'h05, 8'hB4,
                      OPT_MPTCP, 8'd4, 8'hF0, 8'hAA, OPT_EOL}), 11, 0, 8'h00, 0, 1'b0, '0);
        // MPTCP option with no subtype byte
        add_row(ETH_TYPE_VLAN, FLAGS_SYN, 16'h8000, 16'h0001,
                128'({OPT_MPTCP, 8'd2, OPT_EOL}), 3, 0, 8'h00, 0, 1'b0, '0);
        // zero and one length bytes
        add_row(ETH_TYPE_IPV4, FLAGS_SYN, 16'h0102, 16'h0304,
                128'({OPT_TSTAMP, 8'd0}), 2, 4, 8'h00, 0, 1'b0, '0);
        add_row(ETH_TYPE_IPV4, FLAGS_SYN, 16'h0506, 16'h0708,
                128'({OPT_MPTCP, 8'd1}), 2, 4, 8'h00, 0, 1'b0, '0);
        // frame ends inside an option, and before a length byte
        add_row(ETH_TYPE_IPV4, FLAGS_SYN, 16'h1111, 16'h2222,
                128'({OPT_MPTCP, 8'd12, 8'h35, 8'h01}), 4, 0, 8'h00, 0, 1'b0, '0);
        add_row(ETH_TYPE_VLAN, FLAGS_SYN, 16'h3333, 16'h4444,
                128'(OPT_WSCALE), 1, 0, 8'h00, 0, 1'b0, '0);
        // end of list hides a later MPTCP option
        add_row(ETH_TYPE_IPV4, FLAGS_SYN, 16'h5555, 16'h6666,
                128'({OPT_EOL, OPT_MPTCP, 8'd4, 8'h20, OPT_EOL}), 5, 0, 8'h00, 0, 1'b0, '0);
        // only the first MPTCP option counts
        add_row(ETH_TYPE_IPV4, FLAGS_SYN, 16'h7777, 16'h8888,
                128'({OPT_MPTCP, 8'd3, 8'h1F, OPT_MPTCP, 8'd4, 8'h2F, OPT_EOL}), 7, 0,
                8'h00, 0, 1'b0, '0);
        // ends while waiting for a kind byte
        add_row(ETH_TYPE_IPV4, FLAGS_SYN, 16'h9999, 16'hAAAA,
                128'({OPT_NOP, OPT_NOP}), 2, 0, 8'h00, 0, 1'b0, '0);
        // widest option, walk continues into the payload
        add_row(ETH_TYPE_VLAN, FLAGS_SYN, 16'hBBBB, 16'hCCCC,
                128'({8'hFF, 8'hFF}), 2, 260, 8'h55, 0, 1'b0, '0);
        // ethertype one off from IPv4
        add_row(ETH_TYPE_NEAR, FLAGS_SYN, 16'hDDDD, 16'hEEEE, '0, 0, 0, 8'h00, 0, 1'b0, '0);
        // options in a frame without SYN are not walked
        add_row(ETH_TYPE_IPV4, FLAGS_NO_SYN, 16'h0F0F, 16'hF0F0,
                128'({OPT_MPTCP, 8'd4, 8'hF0, OPT_EOL}), 4, 0, 8'h00, 0, 1'b0, '0);

        foreach (frame_rows[i])
        begin
            opt_bytes.delete();
            for (k = 0; k < frame_rows[i].n_opts; k++)
                opt_bytes.push_back(frame_rows[i].opts[8 * (frame_rows[i].n_opts - 1 - k) +: 8]);
            repeat (frame_rows[i].n_pay) opt_bytes.push_back(frame_rows[i].pay_val);
            build_frame(frame_rows[i].etype, frame_rows[i].flags, frame_rows[i].sport,
                        frame_rows[i].dport, frame_rows[i].cut);
            send_frame(frame_rows[i].typed, frame_rows[i].want);
        end

        // Long receiver hold-off while short frames keep coming, so the input stalls
        hold_request = 1'b1;
        repeat (BURST_FRAMES)
        begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
            send_frame(1'b0, '0);
        end

        // Random frames under each idling pattern
        for (ph = 0; ph < 4; ph++)
        begin
            sender_idle_pct    = sender_pcts[ph];
            receiver_stall_pct = receiver_pcts[ph];
            phase_bytes        = 0;
            phase_frames       = 0;
            while (phase_bytes < PHASE_BYTES || phase_frames < PHASE_FRAMES)
            begin
                random_frame();
                phase_bytes += frame_bytes.size();
                phase_frames++;
                send_frame(1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        // Let the last accepted word reach the predictor before draining
        @(posedge clk);

        // Drain, then keep clocking so that any stray word shows
        while (pending_summaries.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: tcp_syn_option_scanner_top.f
hdl/tsos_pkg.sv
hdl/tsos_parser.sv
hdl/tcp_syn_option_scanner_top.sv
tb/sv/tcp_syn_option_scanner_top_test.sv
